// ----- rtl/core/frustum_cull_test_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the frustum cull test block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_TEST_TOP_ASSERT_SVH
`define FRUSTUM_CULL_TEST_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fct_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fct_pkg
// Shared types and constants of the frustum cull test pipeline.
// ---------------------------------------------------------------------------
package fct_pkg;

  // Six planes, each a 64-bit register of four signed 16-bit fields.
  localparam int NUM_PLANES = 6;
  localparam int PLANE_W    = 64;
  localparam int FIELD_W    = 16;
  localparam int CFG_IDX_W  = 3;

  // Normals carry 14 fraction bits; distance and radius are aligned by this.
  localparam int NORM_FRAC  = 14;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] PLANE_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] PLANE_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] PLANE_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] PLANE_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] PLANE_NEAR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] PLANE_FAR    = 3'd5;

  // Test kind carried in the input tuser.
  localparam logic FUNC_BOX    = 1'b0;
  localparam logic FUNC_SPHERE = 1'b1;

  // One plane as held in its register, most significant field first.
  typedef struct packed {
    logic signed [FIELD_W-1:0] distance;
    logic signed [FIELD_W-1:0] nz;
    logic signed [FIELD_W-1:0] ny;
    logic signed [FIELD_W-1:0] nx;
  } plane_t;

  // Load enables of the two stages inside the plane evaluator.
  typedef struct packed {
    logic s2_en;
    logic s3_en;
  } fct_adv_t;

endpackage

// ----- rtl/core/fct_vsel.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fct_vsel
// First stage: picks per plane the positive box vertex or the sphere centre,
// and forms the constant term (plane distance, plus radius for spheres).
// ---------------------------------------------------------------------------
module fct_vsel
  import fct_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int TERM_W      = 17
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  plane_t                        planes_i [NUM_PLANES],
  input  logic                          func_i,
  input  logic signed [COORD_WIDTH-1:0] lo_x_i,
  input  logic signed [COORD_WIDTH-1:0] lo_y_i,
  input  logic signed [COORD_WIDTH-1:0] lo_z_i,
  input  logic signed [COORD_WIDTH-1:0] hi_x_i,
  input  logic signed [COORD_WIDTH-1:0] hi_y_i,
  input  logic signed [COORD_WIDTH-1:0] hi_z_i,
  input  logic        [COORD_WIDTH-2:0] radius_i,
  output logic signed [COORD_WIDTH-1:0] vx_o [NUM_PLANES],
  output logic signed [COORD_WIDTH-1:0] vy_o [NUM_PLANES],
  output logic signed [COORD_WIDTH-1:0] vz_o [NUM_PLANES],
  output logic signed [TERM_W-1:0]      term_o [NUM_PLANES]
);

  logic signed [COORD_WIDTH-1:0] vx_d [NUM_PLANES];
  logic signed [COORD_WIDTH-1:0] vy_d [NUM_PLANES];
  logic signed [COORD_WIDTH-1:0] vz_d [NUM_PLANES];
  logic signed [TERM_W-1:0]      term_d [NUM_PLANES];
  logic signed [TERM_W-1:0]      rad_ext;
  logic                          is_box;

  // The radius is non-negative, so it is zero-extended into the term width.
  assign rad_ext = $signed({{(TERM_W-COORD_WIDTH+1){1'b0}}, radius_i});
  assign is_box  = (func_i == FUNC_BOX);

  // Vertex choice: for a box, hi where the normal component is non-negative, else lo; a sphere always takes lo.
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      vx_d[p]   = (is_box && !planes_i[p].nx[FIELD_W-1]) ? hi_x_i : lo_x_i;
      vy_d[p]   = (is_box && !planes_i[p].ny[FIELD_W-1]) ? hi_y_i : lo_y_i;
      vz_d[p]   = (is_box && !planes_i[p].nz[FIELD_W-1]) ? hi_z_i : lo_z_i;
      term_d[p] = TERM_W'(planes_i[p].distance) + (is_box ? TERM_W'(0) : rad_ext);
    end
  end

  // Stage one payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx_o   <= vx_d;
      vy_o   <= vy_d;
      vz_o   <= vz_d;
      term_o <= term_d;
    end
  end

endmodule

// ----- rtl/core/fct_pdot.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fct_pdot
// One plane's signed distance: products in stage two, then the exact sum and
// its sign in stage three. A negative sum rejects the volume.
// ---------------------------------------------------------------------------
module fct_pdot
  import fct_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int TERM_W      = 17
) (
  input  logic                          clk_i,
  input  fct_adv_t                      adv_i,
  input  plane_t                        plane_i,
  input  logic signed [COORD_WIDTH-1:0] vx_i,
  input  logic signed [COORD_WIDTH-1:0] vy_i,
  input  logic signed [COORD_WIDTH-1:0] vz_i,
  input  logic signed [TERM_W-1:0]      term_i,
  output logic                          reject_o
);

  localparam int PROD_W = COORD_WIDTH + FIELD_W;
  localparam int ACC_W  = (COORD_WIDTH + 19 > 32) ? COORD_WIDTH + 19 : 32;

  logic signed [PROD_W-1:0] px_d, py_d, pz_d;
  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  logic signed [TERM_W-1:0] term_q;
  logic signed [ACC_W-1:0]  sum_d;

  // Stage two: one multiplier per axis.
  assign px_d = PROD_W'(plane_i.nx) * PROD_W'(vx_i);
  assign py_d = PROD_W'(plane_i.ny) * PROD_W'(vy_i);
  assign pz_d = PROD_W'(plane_i.nz) * PROD_W'(vz_i);

  always_ff @(posedge clk_i) begin
    if (adv_i.s2_en) begin
      px_q   <= px_d;
      py_q   <= py_d;
      pz_q   <= pz_d;
      term_q <= term_i;
    end
  end

  // Stage three: exact sum with the term aligned to the product fraction.
  assign sum_d = ACC_W'(px_q) + ACC_W'(py_q) + ACC_W'(pz_q)
               + (ACC_W'(term_q) <<< NORM_FRAC);

  always_ff @(posedge clk_i) begin
    if (adv_i.s3_en) begin
      reject_o <= sum_d[ACC_W-1];
    end
  end

endmodule

// ----- rtl/core/frustum_cull_test_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frustum_cull_test_top
// Tests a box or a sphere against six frustum planes held in registers.
// ---------------------------------------------------------------------------
// Usage: software loads the six planes through the cfg channel (index 0 to
// 5: left, right, bottom, top, near, far; other indexes are dropped) while
// the block is idle. Each slave beat carries one volume: tuser selects a box
// test or a sphere test, tdata holds the coordinates and radius. Each beat
// yields one master beat whose tdata bit 0 is the visible flag.
// The beat passes four register stages (vertex select, multiply, sum and
// sign, combine) before its result reaches the master side. A new beat can
// be taken every cycle while no stall holds the pipeline, so throughput is
// one volume per clock.
// When the receiver holds tready low, the stages fill one by one behind the
// waiting result, and s_axis_tready falls only once every stage holds a
// beat; nothing is dropped or repeated.
// Reset clears all valid bits and all plane registers; with zero planes
// every volume is reported visible. The cfg channel is always ready.
// ---------------------------------------------------------------------------
module frustum_cull_test_top
  import fct_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Fields from bit 0: lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, radius.
  input  logic [((7*COORD_WIDTH+6)/8)*8-1:0] s_axis_tdata,
  // Fields from bit 0: func.
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: visible.
  output logic [7:0]             m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [PLANE_W-1:0]     cfg_data_i
);

  localparam int CW     = COORD_WIDTH;
  localparam int TERM_W = (CW + 1 > FIELD_W + 1) ? CW + 1 : FIELD_W + 1;

  plane_t                 planes_q [NUM_PLANES];
  logic signed [CW-1:0]   vx [NUM_PLANES];
  logic signed [CW-1:0]   vy [NUM_PLANES];
  logic signed [CW-1:0]   vz [NUM_PLANES];
  logic signed [TERM_W-1:0] term [NUM_PLANES];
  logic [NUM_PLANES-1:0]  reject;
  logic                   s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic                   rdy0, rdy1, rdy2, rdy3;
  logic                   visible_q;
  logic                   pipe_full;
  fct_adv_t               adv;

  // Plane registers; writes to indexes beyond the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        planes_q[p] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        PLANE_LEFT, PLANE_RIGHT, PLANE_BOTTOM,
        PLANE_TOP, PLANE_NEAR, PLANE_FAR: begin
          planes_q[cfg_index_i] <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Per-stage ready: a stage loads when it is empty or its successor moves.
  assign rdy3 = !out_valid_q || m_axis_tready;
  assign rdy2 = !s3_valid_q  || rdy3;
  assign rdy1 = !s2_valid_q  || rdy2;
  assign rdy0 = !s1_valid_q  || rdy1;

  assign s_axis_tready = rdy0;
  assign adv.s2_en     = rdy1;
  assign adv.s3_en     = rdy2;

  // Valid bits travelling with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy0) s1_valid_q  <= s_axis_tvalid;
      if (rdy1) s2_valid_q  <= s1_valid_q;
      if (rdy2) s3_valid_q  <= s2_valid_q;
      if (rdy3) out_valid_q <= s3_valid_q;
    end
  end

  // Stage one: vertex and term selection.
  fct_vsel #(
    .COORD_WIDTH (CW),
    .TERM_W      (TERM_W)
  ) u_vsel (
    .clk_i    (clk_i),
    .en_i     (rdy0),
    .planes_i (planes_q),
    .func_i   (s_axis_tuser),
    .lo_x_i   ($signed(s_axis_tdata[0*CW +: CW])),
    .lo_y_i   ($signed(s_axis_tdata[1*CW +: CW])),
    .lo_z_i   ($signed(s_axis_tdata[2*CW +: CW])),
    .hi_x_i   ($signed(s_axis_tdata[3*CW +: CW])),
    .hi_y_i   ($signed(s_axis_tdata[4*CW +: CW])),
    .hi_z_i   ($signed(s_axis_tdata[5*CW +: CW])),
    .radius_i (s_axis_tdata[6*CW +: CW-1]),
    .vx_o     (vx),
    .vy_o     (vy),
    .vz_o     (vz),
    .term_o   (term)
  );

  // Stages two and three: one evaluator per plane.
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    fct_pdot #(
      .COORD_WIDTH (CW),
      .TERM_W      (TERM_W)
    ) u_pdot (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .plane_i  (planes_q[p]),
      .vx_i     (vx[p]),
      .vy_i     (vy[p]),
      .vz_i     (vz[p]),
      .term_i   (term[p]),
      .reject_o (reject[p])
    );
  end

  // Stage four: any rejecting plane culls the volume.
  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      visible_q <= ~|reject;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, visible_q};

  // Checks on the pipeline control.
  assign pipe_full = s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q;

  `include "frustum_cull_test_top_assert.svh"

  `FCT_ASSERT_NOW(a_full_stall, pipe_full && !m_axis_tready, !s_axis_tready, "ready while full")
  `FCT_ASSERT_NEXT(a_s3_moves, s3_valid_q && rdy3, m_axis_tvalid, "stage three beat lost")
  `FCT_ASSERT_NEXT(a_s3_holds, s3_valid_q && !rdy3, s3_valid_q, "stage three beat dropped")

endmodule
